/* rtl/tap_pkg.sv */
// ----------------------------------------------------------------------------
// tap_pkg
// shared types and constants of the tensor axis permute block
// ----------------------------------------------------------------------------
package tap_pkg;

    localparam int CFG_W       = 18;
    localparam int CFG_IDX_W   = 3;
    localparam int EXT_W       = 13;
    localparam int DIGIT_W     = 12;
    localparam int RANK_W      = 3;
    localparam int AXIS_FLD_W  = 3;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int EXTENT_MAX  = 4096;
    localparam int RANK_MIN    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RANK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE0 = 3'd2;

    // register reset values
    localparam logic [RANK_W-1:0] RANK_RESET = 3'd2;
    localparam logic [CFG_W-1:0]  AXIS_RESET = 18'd181896;
    localparam logic [EXT_W-1:0]  SIZE_RESET = 13'd1;

    // item kinds
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_PAST_END = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH = 2'd2;

    typedef struct packed {
        logic init;
        logic size_step;
        logic map;
        logic delta_step;
        logic accept;
        logic pend_move;
    } t_dp_cmd;

    typedef struct packed {
        logic step_zero;
        logic has_result;
    } t_dp_stat;

endpackage

/* rtl/tap_ctrl.sv */
// ----------------------------------------------------------------------------
// tap_ctrl
// sequencer for stride setup and item/result handshake control
// ----------------------------------------------------------------------------
module tap_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_s_valid,
    input  logic              i_m_ready,
    input  tap_pkg::t_dp_stat i_stat,
    output logic              o_s_ready,
    output logic              o_m_valid,
    output tap_pkg::t_dp_cmd  o_cmd
);
    import tap_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_SIZE  = 3'd1;
    localparam logic [2:0] S_MAP   = 3'd2;
    localparam logic [2:0] S_DELTA = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_pend_valid;
    logic       n_pend_valid;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_pend_move;
    logic       w_ready;
    logic       w_accept;

    assign w_pend_move = r_pend_valid && (!r_out_valid || i_m_ready);
    assign w_ready     = (r_state == S_RUN) && (!r_pend_valid || w_pend_move);
    assign w_accept    = i_s_valid && w_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:  n_state = S_SIZE;
            S_SIZE:  if (i_stat.step_zero) n_state = S_MAP;
            S_MAP:   n_state = S_DELTA;
            S_DELTA: if (i_stat.step_zero) n_state = S_RUN;
            S_RUN:   n_state = S_RUN;
            default: n_state = S_INIT;
        endcase
        if (i_cfg_we) begin
            n_state = S_INIT;
        end
    end

    always_comb begin
        n_pend_valid = r_pend_valid;
        if (w_accept && i_stat.has_result) begin
            n_pend_valid = 1'b1;
        end else if (w_pend_move) begin
            n_pend_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_pend_move) begin
            n_out_valid = 1'b1;
        end else if (i_m_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_s_ready        = w_ready;
    assign o_m_valid        = r_out_valid;
    assign o_cmd.init       = (r_state == S_INIT);
    assign o_cmd.size_step  = (r_state == S_SIZE);
    assign o_cmd.map        = (r_state == S_MAP);
    assign o_cmd.delta_step = (r_state == S_DELTA);
    assign o_cmd.accept     = w_accept;
    assign o_cmd.pend_move  = w_pend_move;

endmodule

/* rtl/tap_dp.sv */
// ----------------------------------------------------------------------------
// tap_dp
// config registers, element store, stride setup and index odometer
// ----------------------------------------------------------------------------
module tap_dp #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int MAX_RANK     = 6,
    parameter int WORD_BITS    = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [tap_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [tap_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                             i_op,
    input  logic [tap_pkg::WORD_W-1:0]       i_elem,
    input  tap_pkg::t_dp_cmd                 i_cmd,
    output tap_pkg::t_dp_stat                o_stat,
    output logic [tap_pkg::WORD_W-1:0]       o_out_word,
    output logic                             o_out_final,
    output logic [tap_pkg::STATUS_W-1:0]     o_out_status
);
    import tap_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 2);
    localparam int RIDX_W  = $clog2(MAX_RANK);
    localparam int STORE_W = (WORD_BITS < WORD_W) ? WORD_BITS : WORD_W;
    localparam int MUL_W   = CNT_W + EXT_W;
    localparam int WRAP_W  = DIGIT_W + ADDR_W;

    // configuration
    logic [RANK_W-1:0]  r_cfg_rank;
    logic [CFG_W-1:0]   r_cfg_axis;
    logic [EXT_W-1:0]   r_cfg_size [MAX_RANK];

    // walk setup
    logic [CNT_W-1:0]   r_shape;
    logic [RIDX_W-1:0]  r_step;
    logic [ADDR_W-1:0]  r_in_stride [MAX_RANK];
    logic [ADDR_W-1:0]  r_stride    [MAX_RANK];
    logic [DIGIT_W-1:0] r_ext_m1    [MAX_RANK];
    logic [ADDR_W-1:0]  r_delta     [MAX_RANK];
    logic [ADDR_W-1:0]  r_acc;

    // walk state
    logic [CNT_W-1:0]   r_loaded;
    logic [CNT_W-1:0]   r_emitted;
    logic               r_overflow;
    logic [DIGIT_W-1:0] r_digit [MAX_RANK];
    logic [ADDR_W-1:0]  r_offset;

    // store and result stages
    logic [STORE_W-1:0] r_mem [MAX_ELEMENTS];
    logic [STORE_W-1:0] r_rd_data;
    logic               r_pend_sel;
    logic               r_pend_final;
    logic [STATUS_W-1:0] r_pend_status;
    logic [WORD_W-1:0]  r_out_word;
    logic               r_out_final;
    logic [STATUS_W-1:0] r_out_status;

    logic [RANK_W-1:0]  w_rank;
    logic [RIDX_W-1:0]  w_rank_m1;
    logic [EXT_W-1:0]   w_ext [MAX_RANK];
    logic [MUL_W-1:0]   w_mul;
    logic [CNT_W-1:0]   w_mul_cap;
    logic [WRAP_W-1:0]  w_wrap;
    logic [AXIS_FLD_W-1:0] w_field [MAX_RANK];
    logic [RIDX_W-1:0]  w_ax [MAX_RANK];
    logic [MAX_RANK-1:0] w_seen;
    logic               w_perm_ok;
    logic [DIGIT_W-1:0] n_digit [MAX_RANK];
    logic [ADDR_W-1:0]  w_delta_sel;
    logic               w_is_read;
    logic               w_load_full;
    logic               w_past;
    logic               w_short;
    logic               w_emit;
    logic               w_load_ok;
    logic [CNT_W-1:0]   w_emitted_inc;

    // effective rank and extents
    always_comb begin
        w_rank = r_cfg_rank;
        if (r_cfg_rank < RANK_W'(RANK_MIN)) begin
            w_rank = RANK_W'(RANK_MIN);
        end else if (r_cfg_rank > RANK_W'(MAX_RANK)) begin
            w_rank = RANK_W'(MAX_RANK);
        end
        for (int d = 0; d < MAX_RANK; d++) begin
            w_ext[d] = r_cfg_size[d];
            if (r_cfg_size[d] == '0) begin
                w_ext[d] = EXT_W'(1);
            end else if (r_cfg_size[d] > EXT_W'(EXTENT_MAX)) begin
                w_ext[d] = EXT_W'(EXTENT_MAX);
            end
        end
    end

    assign w_rank_m1 = RIDX_W'(w_rank - RANK_W'(1));

    // shape product, capped one above capacity
    assign w_mul     = MUL_W'(r_shape) * MUL_W'(w_ext[r_step]);
    assign w_mul_cap = (w_mul > MUL_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS + 1)
                                                      : CNT_W'(w_mul);
    assign w_wrap    = WRAP_W'(r_ext_m1[r_step]) * WRAP_W'(r_stride[r_step]);

    // axis order check, identity when not a permutation
    always_comb begin
        w_seen    = '0;
        w_perm_ok = 1'b1;
        for (int i = 0; i < MAX_RANK; i++) begin
            w_field[i] = r_cfg_axis[AXIS_FLD_W*i +: AXIS_FLD_W];
            if (i < int'(w_rank)) begin
                if (w_field[i] >= AXIS_FLD_W'(w_rank) || w_seen[w_field[i][RIDX_W-1:0]]) begin
                    w_perm_ok = 1'b0;
                end else begin
                    w_seen[w_field[i][RIDX_W-1:0]] = 1'b1;
                end
            end
        end
        for (int i = 0; i < MAX_RANK; i++) begin
            w_ax[i] = (w_perm_ok && i < int'(w_rank)) ? w_field[i][RIDX_W-1:0]
                                                       : RIDX_W'(i);
        end
    end

    // odometer, innermost position counts fastest
    always_comb begin
        logic carry;
        carry       = 1'b0;
        w_delta_sel = '0;
        for (int p = MAX_RANK - 1; p >= 0; p--) begin
            n_digit[p] = r_digit[p];
            if (p == int'(w_rank) - 1) begin
                carry = 1'b1;
            end
            if (carry) begin
                if (r_digit[p] == r_ext_m1[p]) begin
                    n_digit[p] = '0;
                end else begin
                    n_digit[p]  = r_digit[p] + DIGIT_W'(1);
                    w_delta_sel = w_delta_sel | r_delta[p];
                end
            end
            carry = carry && (r_digit[p] == r_ext_m1[p]);
        end
    end

    // item decode
    assign w_is_read     = (i_op == OP_READ);
    assign w_load_full   = (r_loaded >= r_shape) || (r_loaded >= CNT_W'(MAX_ELEMENTS));
    assign w_past        = (r_emitted >= r_shape);
    assign w_short       = (r_loaded < r_shape);
    assign w_emit        = w_is_read && !w_past && !w_short;
    assign w_load_ok     = !w_is_read && !w_load_full;
    assign w_emitted_inc = r_emitted + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rank <= RANK_RESET;
            r_cfg_axis <= AXIS_RESET;
            for (int d = 0; d < MAX_RANK; d++) begin
                r_cfg_size[d] <= SIZE_RESET;
                r_digit[d]    <= '0;
            end
            r_loaded   <= '0;
            r_emitted  <= '0;
            r_overflow <= 1'b0;
            r_offset   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_RANK) begin
                r_cfg_rank <= i_cfg_wdata[RANK_W-1:0];
            end
            if (i_cfg_addr == REG_AXIS) begin
                r_cfg_axis <= i_cfg_wdata;
            end
            for (int d = 0; d < MAX_RANK; d++) begin
                if (i_cfg_addr == REG_SIZE0 + CFG_IDX_W'(d)) begin
                    r_cfg_size[d] <= i_cfg_wdata[EXT_W-1:0];
                end
                r_digit[d] <= '0;
            end
            r_loaded   <= '0;
            r_emitted  <= '0;
            r_overflow <= 1'b0;
            r_offset   <= '0;
        end else if (i_cmd.accept) begin
            if (w_load_ok) begin
                r_loaded <= r_loaded + CNT_W'(1);
            end
            if (!w_is_read && w_load_full) begin
                r_overflow <= 1'b1;
            end
            if (w_emit) begin
                r_emitted <= w_emitted_inc;
                r_offset  <= r_offset + w_delta_sel;
                for (int p = 0; p < MAX_RANK; p++) begin
                    r_digit[p] <= n_digit[p];
                end
            end
        end
    end

    // stride and step setup
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_shape <= CNT_W'(1);
            r_step  <= w_rank_m1;
        end else if (i_cmd.size_step) begin
            r_in_stride[r_step] <= ADDR_W'(r_shape);
            r_shape             <= w_mul_cap;
            if (r_step != '0) begin
                r_step <= r_step - RIDX_W'(1);
            end
        end else if (i_cmd.map) begin
            r_step <= w_rank_m1;
            r_acc  <= '0;
            for (int i = 0; i < MAX_RANK; i++) begin
                if (i < int'(w_rank)) begin
                    r_stride[i] <= r_in_stride[w_ax[i]];
                    r_ext_m1[i] <= DIGIT_W'(w_ext[w_ax[i]] - EXT_W'(1));
                end else begin
                    r_stride[i] <= '0;
                    r_ext_m1[i] <= '0;
                end
            end
        end else if (i_cmd.delta_step) begin
            r_delta[r_step] <= r_stride[r_step] - r_acc;
            r_acc           <= r_acc + ADDR_W'(w_wrap);
            if (r_step != '0) begin
                r_step <= r_step - RIDX_W'(1);
            end
        end
    end

    // element store, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_load_ok) begin
            r_mem[r_loaded[ADDR_W-1:0]] <= i_elem[STORE_W-1:0];
        end
        if (i_cmd.accept && w_emit) begin
            r_rd_data <= r_mem[r_offset];
        end
    end

    // result stages
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pend_sel   <= w_emit;
            r_pend_final <= w_emit && (w_emitted_inc == r_shape);
            if (w_is_read && w_past) begin
                r_pend_status <= STAT_PAST_END;
            end else if (!w_is_read || w_short) begin
                r_pend_status <= STAT_MISMATCH;
            end else begin
                r_pend_status <= r_overflow ? STAT_MISMATCH : STAT_OK;
            end
        end
        if (i_cmd.pend_move) begin
            r_out_word   <= r_pend_sel ? WORD_W'(r_rd_data) : '0;
            r_out_final  <= r_pend_final;
            r_out_status <= r_pend_status;
        end
    end

    assign o_stat.step_zero  = (r_step == '0);
    assign o_stat.has_result = w_is_read || w_load_full;
    assign o_out_word        = r_out_word;
    assign o_out_final       = r_out_final;
    assign o_out_status      = r_out_status;

endmodule

/* rtl/tensor_axis_permute_top.sv */
// ----------------------------------------------------------------------------
// tensor_axis_permute_top
// n-dimensional tensor transpose over a loaded element store
// ----------------------------------------------------------------------------
// Program rank, axis order and extents on the cfg port, then send items on
// s_axis: tuser low loads the next row-major element from tdata, tuser high
// asks for the next element of the permuted tensor. Loads give no result
// unless dropped; reads always give one result on m_axis (tdata element,
// tlast on the last element, tuser status).
// After reset and after every cfg write the block sets up its strides and
// odometer deltas, holding s_axis_tready low until that setup is done.
// Once set up, one item is taken per cycle while the result stages have
// room. Each result goes through the registered store read and pending
// stage, then the output register. The odometer carry and one delta add
// settle in the same cycle; the store has one write and one read port.
// A stalled m_axis holds its result; one more result waits in the stage
// behind it, after which s_axis_tready drops until the receiver takes one.
// Reset is synchronous and clears the load and emit counts and the walk.
// ----------------------------------------------------------------------------
module tensor_axis_permute_top #(
    parameter int MAX_ELEMENTS = 4096,
    parameter int MAX_RANK     = 6,
    parameter int WORD_BITS    = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tap_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [tap_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tap_pkg::WORD_W-1:0]     s_axis_tdata,  // element_word
    input  logic                           s_axis_tuser,  // op
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [tap_pkg::WORD_W-1:0]     m_axis_tdata,  // out_word
    output logic                           m_axis_tlast,
    output logic [tap_pkg::STATUS_W-1:0]   m_axis_tuser   // status
);
    import tap_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    tap_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_stat    (w_stat),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (w_cmd)
    );

    tap_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_RANK     (MAX_RANK),
        .WORD_BITS    (WORD_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_op         (s_axis_tuser),
        .i_elem       (s_axis_tdata),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_out_word   (m_axis_tdata),
        .o_out_final  (m_axis_tlast),
        .o_out_status (m_axis_tuser)
    );

    a_cfg_blocks_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !s_axis_tready)
        else $error("item taken right after a cfg write");

    a_past_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == STAT_PAST_END |-> !m_axis_tlast && m_axis_tdata == '0)
        else $error("read past end carries data or last");

    a_accept_not_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.accept |-> !(w_cmd.init || w_cmd.size_step || w_cmd.map || w_cmd.delta_step))
        else $error("item taken during stride setup");

endmodule
